// ===== sv/tsdr_pkg.sv =====
// Shared types and constants for the text screen delta refresh block.
// Holds the item, result, configuration, command and status types.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tsdr_pkg;

    // Field widths fixed by the item and result formats.
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 10;
    localparam int CHAR_W  = 8;
    localparam int STYLE_W = 5;
    localparam int GLYPH_W = STYLE_W + CHAR_W;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int SCAN_W  = 13;
    localparam int DIV_CW  = $clog2(SCAN_W + 1);

    // Configuration port geometry.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OFFSET_COL    = 3'd0;
    localparam logic [2:0] REG_OFFSET_ROW    = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT     = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP      = 3'd3;
    localparam logic [2:0] REG_CLIP_WIDTH    = 3'd4;
    localparam logic [2:0] REG_CLIP_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

    // Record kinds.
    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_PUT   = 2'd1,
        FUNC_SYNC  = 2'd2,
        FUNC_INVAL = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        RESTYLE_KEEP      = 2'd0,
        RESTYLE_SET       = 2'd1,
        RESTYLE_RESET_SET = 2'd2
    } t_restyle;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT,
        S_WIPE_DRAWN,
        S_WIPE_SHOWN,
        S_SYNC_CHK,
        S_DIV,
        S_ADDR,
        S_READ,
        S_CMP,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] offset_col;
        logic [POS_W-1:0] offset_row;
        logic [COL_W-1:0] clip_left;
        logic [ROW_W-1:0] clip_top;
        logic [COL_W-1:0] clip_width;
        logic [ROW_W-1:0] clip_height;
        logic [COL_W-1:0] screen_width;
        logic [ROW_W-1:0] screen_height;
    } t_cfg;

    typedef struct packed {
        t_func              func;
        logic [POS_W-1:0]   pos_col;
        logic [POS_W-1:0]   pos_row;
        logic [CHAR_W-1:0]  glyph_char;
        logic [STYLE_W-1:0] glyph_style;
    } t_item;

    typedef struct packed {
        logic               record_kind;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [CHAR_W-1:0]  out_char;
        logic [STYLE_W-1:0] out_style;
        t_restyle           restyle;
        logic               move_cursor;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sweep_init;
        logic sweep_drawn;
        logic sweep_shown;
        logic capture;
        logic put_write;
        logic div_start;
        logic div_step;
        logic set_addr;
        logic adv_scan;
        logic load_cell;
        logic load_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic scan_end;
        logic div_done;
        logic cell_same;
        logic out_free;
    } t_status;

endpackage

// ===== sv/tsdr_if.sv =====
// Valid/ready channel interfaces for the input items and the result records.
// Depends on tsdr_pkg for the field widths and types.
`timescale 1ns / 1ps

interface tsdr_in_if;
    import tsdr_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   pos_col;
    logic [POS_W-1:0]   pos_row;
    logic [CHAR_W-1:0]  glyph_char;
    logic [STYLE_W-1:0] glyph_style;

    modport source (
        output valid, func, pos_col, pos_row, glyph_char, glyph_style,
        input  ready
    );
    modport sink (
        input  valid, func, pos_col, pos_row, glyph_char, glyph_style,
        output ready
    );
endinterface

interface tsdr_out_if;
    import tsdr_pkg::*;

    logic               valid;
    logic               ready;
    logic               record_kind;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [CHAR_W-1:0]  out_char;
    logic [STYLE_W-1:0] out_style;
    logic [1:0]         restyle;
    logic               move_cursor;

    modport source (
        output valid, record_kind, cell_row, cell_col, out_char, out_style,
               restyle, move_cursor,
        input  ready
    );
    modport sink (
        input  valid, record_kind, cell_row, cell_col, out_char, out_style,
               restyle, move_cursor,
        output ready
    );
endinterface

// ===== sv/tsdr_ctrl.sv =====
// Controller state machine: sequences clearing sweeps, puts and sync steps.
// Depends on tsdr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module tsdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tsdr_pkg::t_func   i_in_func,
    output logic              o_in_ready,
    input  tsdr_pkg::t_status i_status,
    output tsdr_pkg::t_cmd    o_cmd
);
    import tsdr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass over both stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_init = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_func)
                        FUNC_BEGIN: n_state = S_WIPE_DRAWN;
                        FUNC_PUT:   n_state = S_PUT;
                        FUNC_SYNC:  n_state = S_SYNC_CHK;
                        FUNC_INVAL: n_state = S_WIPE_SHOWN;
                    endcase
                end
            end
            S_PUT: begin
                o_cmd.put_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_WIPE_DRAWN: begin
                o_cmd.sweep_drawn = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_WIPE_SHOWN: begin
                o_cmd.sweep_shown = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SYNC_CHK: begin
                if (i_status.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_ADDR;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ADDR: begin
                o_cmd.set_addr = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.adv_scan = 1'b1;
                n_state        = i_status.cell_same ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_cell = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== sv/tsdr_dp.sv =====
// Datapath: shown and drawn glyph stores, put clipping, scan divider,
// cursor and style tracking, and the output record register.
// Depends on tsdr_pkg; driven by commands from tsdr_ctrl.
`timescale 1ns / 1ps

module tsdr_dp #(
    parameter int ROWS   = 50,
    parameter int COLS   = 160,
    parameter int STYLES = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsdr_pkg::t_cfg    i_cfg,
    input  tsdr_pkg::t_item   i_item,
    input  tsdr_pkg::t_cmd    i_cmd,
    output tsdr_pkg::t_status o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output tsdr_pkg::t_result o_result
);
    import tsdr_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [8:0] COLS_LIM = 9'(COLS);
    localparam logic [8:0] ROWS_LIM = 9'(ROWS);
    localparam logic signed [11:0] COLS_S = 12'(COLS);
    localparam logic signed [11:0] ROWS_S = 12'(ROWS);
    localparam logic [5:0] STYLES_LIM = 6'(STYLES);
    localparam logic [GLYPH_W-1:0] SPACE_GLYPH = GLYPH_W'(SPACE_CHAR);

    // Captured item.
    t_item r_item;

    // Glyph stores and their registered read data.
    logic [GLYPH_W-1:0] r_shown_mem [CELLS];
    logic [GLYPH_W-1:0] r_drawn_mem [CELLS];
    logic [GLYPH_W-1:0] r_shown_q;
    logic [GLYPH_W-1:0] r_drawn_q;

    // Sweep, scan and cursor state.
    logic [ADDR_W-1:0]  r_sweep;
    logic [SCAN_W-1:0]  r_scan;
    logic [COL_W-1:0]   r_cursor_col;
    logic [ROW_W-1:0]   r_cursor_row;
    logic [STYLE_W-1:0] r_active_style;
    logic [ADDR_W-1:0]  r_cell_addr;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;

    // Restoring divider state.
    logic [SCAN_W-1:0]  r_div_quo;
    logic [COL_W-1:0]   r_div_rem;
    logic [DIV_CW-1:0]  r_div_cnt;

    logic               r_out_valid;
    t_result            r_result;

    // Effective screen size and scan length.
    logic [COL_W-1:0]   w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [13:0]        scan_total;

    assign w_eff = ({1'b0, i_cfg.screen_width} > COLS_LIM) ? COLS_LIM[COL_W-1:0]
                                                           : i_cfg.screen_width;
    assign h_eff = ({3'b0, i_cfg.screen_height} > ROWS_LIM) ? ROWS_LIM[ROW_W-1:0]
                                                            : i_cfg.screen_height;
    assign scan_total = 14'(w_eff) * 14'(h_eff);

    // Put position after the offset, and the clip and store bounds test.
    logic signed [11:0] put_x;
    logic signed [11:0] put_y;
    logic [8:0]         clip_right;
    logic [6:0]         clip_bottom;
    logic               put_ok;
    logic [ADDR_W-1:0]  put_addr;
    logic [CHAR_W-1:0]  put_char;
    logic [STYLE_W-1:0] put_style;

    always_comb begin
        put_x = {{2{r_item.pos_col[POS_W-1]}}, r_item.pos_col}
              + {{2{i_cfg.offset_col[POS_W-1]}}, i_cfg.offset_col};
        put_y = {{2{r_item.pos_row[POS_W-1]}}, r_item.pos_row}
              + {{2{i_cfg.offset_row[POS_W-1]}}, i_cfg.offset_row};
        clip_right  = {1'b0, i_cfg.clip_left} + {1'b0, i_cfg.clip_width};
        clip_bottom = {1'b0, i_cfg.clip_top} + {1'b0, i_cfg.clip_height};
        put_ok = (put_x >= $signed({4'b0, i_cfg.clip_left}))
              && (put_x <  $signed({3'b0, clip_right}))
              && (put_y >= $signed({6'b0, i_cfg.clip_top}))
              && (put_y <  $signed({5'b0, clip_bottom}))
              && (put_x >= 12'sd0) && (put_x < COLS_S)
              && (put_y >= 12'sd0) && (put_y < ROWS_S);
        put_addr = ADDR_W'(unsigned'(put_y)) * COLS_A + ADDR_W'(unsigned'(put_x));
        put_char = (r_item.glyph_char == SPACE_CHAR) ? '0 : r_item.glyph_char;
        put_style = ({1'b0, r_item.glyph_style} >= STYLES_LIM) ? '0
                                                                : r_item.glyph_style;
    end

    // Store write ports.
    logic               drawn_we;
    logic [ADDR_W-1:0]  drawn_waddr;
    logic [GLYPH_W-1:0] drawn_wdata;
    logic               shown_we;
    logic [ADDR_W-1:0]  shown_waddr;
    logic [GLYPH_W-1:0] shown_wdata;
    logic               drawn_sweep;

    always_comb begin
        drawn_sweep = i_cmd.sweep_init | i_cmd.sweep_drawn;
        drawn_we    = drawn_sweep | (i_cmd.put_write & put_ok);
        drawn_waddr = drawn_sweep ? r_sweep : put_addr;
        drawn_wdata = drawn_sweep ? '0 : {put_style, put_char};
        shown_we    = i_cmd.sweep_init | i_cmd.sweep_shown | i_cmd.load_cell;
        shown_waddr = i_cmd.load_cell ? r_cell_addr : r_sweep;
        if (i_cmd.load_cell) begin
            shown_wdata = r_drawn_q;
        end else if (i_cmd.sweep_init) begin
            shown_wdata = SPACE_GLYPH;
        end else begin
            shown_wdata = '0;
        end
    end

    // Drawn store.
    always_ff @(posedge i_clk) begin
        if (drawn_we) begin
            r_drawn_mem[drawn_waddr] <= drawn_wdata;
        end
        r_drawn_q <= r_drawn_mem[r_cell_addr];
    end

    // Shown store.
    always_ff @(posedge i_clk) begin
        if (shown_we) begin
            r_shown_mem[shown_waddr] <= shown_wdata;
        end
        r_shown_q <= r_shown_mem[r_cell_addr];
    end

    // Sweep address counter, returns to zero after the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_init | i_cmd.sweep_drawn | i_cmd.sweep_shown) begin
            r_sweep <= (r_sweep == LAST_ADDR) ? '0 : r_sweep + 1'b1;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Restoring divider: scan index over the screen width, one bit a cycle.
    logic [COL_W:0] div_trial;
    assign div_trial = {r_div_rem, r_div_quo[SCAN_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DIV_CW'(SCAN_W);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_quo <= r_scan;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (div_trial >= {1'b0, w_eff}) begin
                r_div_rem <= COL_W'(div_trial - {1'b0, w_eff});
                r_div_quo <= {r_div_quo[SCAN_W-2:0], 1'b1};
            end else begin
                r_div_rem <= div_trial[COL_W-1:0];
                r_div_quo <= {r_div_quo[SCAN_W-2:0], 1'b0};
            end
        end
    end

    // Cell position and store address from the quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_addr) begin
            r_row       <= r_div_quo[ROW_W-1:0];
            r_col       <= r_div_rem;
            r_cell_addr <= ADDR_W'(r_div_quo[ROW_W-1:0]) * COLS_A + ADDR_W'(r_div_rem);
        end
    end

    // Fields of a changed cell.
    logic [STYLE_W-1:0] cell_style;
    logic [CHAR_W-1:0]  cell_char;
    t_restyle           cell_restyle;
    logic               cell_move;
    logic [COL_W:0]     col_next;

    always_comb begin
        cell_style = r_drawn_q[GLYPH_W-1:CHAR_W];
        cell_char  = r_drawn_q[CHAR_W-1:0];
        if (cell_style == r_active_style) begin
            cell_restyle = RESTYLE_KEEP;
        end else if (cell_style != '0) begin
            cell_restyle = RESTYLE_RESET_SET;
        end else begin
            cell_restyle = RESTYLE_SET;
        end
        cell_move = (r_col != r_cursor_col) || (r_row != r_cursor_row);
        col_next  = {1'b0, r_col} + 1'b1;
    end

    // Scan index, cursor and active style.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan         <= '0;
            r_cursor_col   <= '0;
            r_cursor_row   <= '0;
            r_active_style <= '0;
        end else begin
            if (i_cmd.adv_scan) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.load_done) begin
                r_scan         <= '0;
                r_active_style <= '0;
            end
            if (i_cmd.load_cell) begin
                r_active_style <= cell_style;
                if (col_next >= {1'b0, w_eff}) begin
                    r_cursor_col <= '0;
                    r_cursor_row <= r_row + 1'b1;
                end else begin
                    r_cursor_col <= col_next[COL_W-1:0];
                    r_cursor_row <= r_row;
                end
            end
        end
    end

    // Output record register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_cell | i_cmd.load_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output record register: payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cell) begin
            r_result.record_kind <= KIND_CELL;
            r_result.cell_row    <= r_row;
            r_result.cell_col    <= r_col;
            r_result.out_char    <= (cell_char == '0) ? SPACE_CHAR : cell_char;
            r_result.out_style   <= cell_style;
            r_result.restyle     <= cell_restyle;
            r_result.move_cursor <= cell_move;
        end else if (i_cmd.load_done) begin
            // A done record carries only its kind; every other field is zero.
            r_result <= t_result'({KIND_DONE, {($bits(t_result) - 1){1'b0}}});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign o_status.sweep_last = (r_sweep == LAST_ADDR);
    assign o_status.scan_end   = ({1'b0, r_scan} >= scan_total);
    assign o_status.div_done   = (r_div_cnt == '0);
    assign o_status.cell_same  = (r_shown_q == r_drawn_q);
    assign o_status.out_free   = ~r_out_valid | i_out_ready;

endmodule

// ===== sv/text_screen_delta_refresh.sv =====
// Text screen delta refresh: a sync step runs the 13-step restoring divider that splits
// the scan index into row and column, then compares the cell in both stores; a changed
// cell or a done record may wait for a full output register. Begin frame and invalidate
// sweep their store, one store entry a cycle. One item is in work at a time; a finished
// record waits in the output register while the next item is taken. Reset clears both
// stores.
`timescale 1ns / 1ps

module text_screen_delta_refresh #(
    parameter int ROWS   = 50,
    parameter int COLS   = 160,
    parameter int STYLES = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsdr_pkg::CFG_AW-1:0] paddr,
    input  logic [tsdr_pkg::CFG_DW-1:0] pwdata,
    output logic [tsdr_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    tsdr_in_if.sink                     i_in_chan,
    tsdr_out_if.source                  o_out_chan
);
    import tsdr_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    out_valid;
    logic    in_ready;
    logic    cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel & penable & pwrite;

    // Configuration registers, written in the access cycle of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_OFFSET_COL:    r_cfg.offset_col    <= pwdata[POS_W-1:0];
                REG_OFFSET_ROW:    r_cfg.offset_row    <= pwdata[POS_W-1:0];
                REG_CLIP_LEFT:     r_cfg.clip_left     <= pwdata[COL_W-1:0];
                REG_CLIP_TOP:      r_cfg.clip_top      <= pwdata[ROW_W-1:0];
                REG_CLIP_WIDTH:    r_cfg.clip_width    <= pwdata[COL_W-1:0];
                REG_CLIP_HEIGHT:   r_cfg.clip_height   <= pwdata[ROW_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[COL_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[ROW_W-1:0];
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_OFFSET_COL:    prdata = CFG_DW'(r_cfg.offset_col);
            REG_OFFSET_ROW:    prdata = CFG_DW'(r_cfg.offset_row);
            REG_CLIP_LEFT:     prdata = CFG_DW'(r_cfg.clip_left);
            REG_CLIP_TOP:      prdata = CFG_DW'(r_cfg.clip_top);
            REG_CLIP_WIDTH:    prdata = CFG_DW'(r_cfg.clip_width);
            REG_CLIP_HEIGHT:   prdata = CFG_DW'(r_cfg.clip_height);
            REG_SCREEN_WIDTH:  prdata = CFG_DW'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = CFG_DW'(r_cfg.screen_height);
        endcase
    end

    // Input channel payload.
    always_comb begin
        in_item.func        = t_func'(i_in_chan.func);
        in_item.pos_col     = i_in_chan.pos_col;
        in_item.pos_row     = i_in_chan.pos_row;
        in_item.glyph_char  = i_in_chan.glyph_char;
        in_item.glyph_style = i_in_chan.glyph_style;
    end

    assign i_in_chan.ready = in_ready;

    tsdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_chan.valid),
        .i_in_func  (in_item.func),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tsdr_dp #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .STYLES (STYLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_out_chan.ready),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    // Output channel payload.
    assign o_out_chan.valid       = out_valid;
    assign o_out_chan.record_kind = result.record_kind;
    assign o_out_chan.cell_row    = result.cell_row;
    assign o_out_chan.cell_col    = result.cell_col;
    assign o_out_chan.out_char    = result.out_char;
    assign o_out_chan.out_style   = result.out_style;
    assign o_out_chan.restyle     = result.restyle;
    assign o_out_chan.move_cursor = result.move_cursor;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the text screen delta refresh block.
// Uses tsdr_pkg, the tsdr_in_if / tsdr_out_if channel interfaces and the block's top level.
// A local screen model predicts every cell update and done record of the sync scan.
`timescale 1ns / 1ps

module tb_top;
    import tsdr_pkg::*;

    localparam int ROWS           = 50;
    localparam int COLS           = 160;
    localparam int STYLES         = 30;
    localparam int CELLS          = ROWS * COLS;
    localparam int SWEEP_CYCLES   = ROWS * COLS;
    localparam int MISMATCH_SHOWN = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    tsdr_in_if  cmd_chan ();
    tsdr_out_if rec_chan ();

    text_screen_delta_refresh #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .STYLES (STYLES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_chan  (cmd_chan),
        .o_out_chan (rec_chan)
    );

    // Screen model state and its copy of the registers.
    logic [GLYPH_W-1:0] shown_img [CELLS];
    logic [GLYPH_W-1:0] drawn_img [CELLS];
    int                 cur_col;
    int                 cur_row;
    int                 scan_pos;
    logic [STYLE_W-1:0] cur_style;
    t_cfg               cfg_shadow;

    t_item   screen_cmds [$];
    t_result due_records [$];
    int      bad_records;
    logic    item_taken;

    // Sender and receiver pacing.
    int burst_left;
    int gap_left;
    int rdy_mode;
    int rdy_left;

    t_item   taken_cmd;
    t_result got_rec;
    t_result want_rec;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Applies one accepted command to the screen model and queues any record it causes.
    function automatic void apply_screen_cmd(input t_item it);
        t_result            rec;
        int                 x, y, w, h, total, row, col, cell_idx;
        logic [CHAR_W-1:0]  ch;
        logic [STYLE_W-1:0] st;
        rec = '0;
        case (it.func)
            FUNC_BEGIN: begin
                foreach (drawn_img[i]) drawn_img[i] = '0;
            end
            FUNC_INVAL: begin
                foreach (shown_img[i]) shown_img[i] = '0;
            end
            FUNC_PUT: begin
                x  = int'($signed(it.pos_col)) + int'($signed(cfg_shadow.offset_col));
                y  = int'($signed(it.pos_row)) + int'($signed(cfg_shadow.offset_row));
                ch = it.glyph_char;
                st = it.glyph_style;
                // Drop glyphs outside the clip rectangle or the store.
                if (x >= int'(cfg_shadow.clip_left)
                        && x < int'(cfg_shadow.clip_left) + int'(cfg_shadow.clip_width)
                        && y >= int'(cfg_shadow.clip_top)
                        && y < int'(cfg_shadow.clip_top) + int'(cfg_shadow.clip_height)
                        && x >= 0 && x < COLS && y >= 0 && y < ROWS) begin
                    if (ch == SPACE_CHAR) ch = '0;
                    if (int'(st) >= STYLES) st = '0;
                    drawn_img[y * COLS + x] = {st, ch};
                end
            end
            FUNC_SYNC: begin
                w = (int'(cfg_shadow.screen_width) > COLS) ? COLS : int'(cfg_shadow.screen_width);
                h = (int'(cfg_shadow.screen_height) > ROWS) ? ROWS
                                                            : int'(cfg_shadow.screen_height);
                total = w * h;
                if (scan_pos >= total) begin
                    // End of scan, also after the screen shrank or when it is empty.
                    rec.record_kind = KIND_DONE;
                    scan_pos  = 0;
                    cur_style = '0;
                    due_records.push_back(rec);
                end else begin
                    row = scan_pos / w;
                    col = scan_pos % w;
                    scan_pos = (scan_pos + 1) % (1 << SCAN_W);
                    cell_idx = row * COLS + col;
                    if (shown_img[cell_idx] != drawn_img[cell_idx]) begin
                        shown_img[cell_idx] = drawn_img[cell_idx];
                        st = drawn_img[cell_idx][GLYPH_W-1:CHAR_W];
                        ch = drawn_img[cell_idx][CHAR_W-1:0];
                        rec.record_kind = KIND_CELL;
                        rec.cell_row    = ROW_W'(row);
                        rec.cell_col    = COL_W'(col);
                        rec.out_char    = (ch == '0) ? SPACE_CHAR : ch;
                        rec.out_style   = st;
                        if (st == cur_style) rec.restyle = RESTYLE_KEEP;
                        else if (st != '0) rec.restyle = RESTYLE_RESET_SET;
                        else rec.restyle = RESTYLE_SET;
                        cur_style = st;
                        rec.move_cursor = (col != cur_col || row != cur_row);
                        // Tracked cursor steps right and wraps at the screen width.
                        col++;
                        if (col >= w) begin
                            col = 0;
                            row++;
                        end
                        cur_col = col & 'hFF;
                        cur_row = row & 'h3F;
                        due_records.push_back(rec);
                    end
                end
            end
        endcase
    endfunction

    function automatic int rand_pos();
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    function automatic void push_cmd(input t_func f, input int pc, input int pr,
                                     input int ch, input int st);
        t_item it;
        it.func        = f;
        it.pos_col     = POS_W'(pc);
        it.pos_row     = POS_W'(pr);
        it.glyph_char  = CHAR_W'(ch);
        it.glyph_style = STYLE_W'(st);
        screen_cmds.push_back(it);
    endfunction

    // Put aimed at the clip rectangle or the scanned screen, with some fully random ones.
    function automatic void push_random_put(input int w, input int h);
        int px, py, tx, ty, roll, ch;
        if ($urandom_range(0, 9) < 2) begin
            px = rand_pos();
            py = rand_pos();
        end else begin
            if ($urandom_range(0, 1) == 1 && cfg_shadow.clip_width != '0
                    && cfg_shadow.clip_height != '0) begin
                tx = int'(cfg_shadow.clip_left)
                     + int'($urandom_range(0, int'(cfg_shadow.clip_width) - 1));
                ty = int'(cfg_shadow.clip_top)
                     + int'($urandom_range(0, int'(cfg_shadow.clip_height) - 1));
            end else begin
                tx = int'($urandom_range(0, w));
                ty = int'($urandom_range(0, h));
            end
            px = tx - int'($signed(cfg_shadow.offset_col));
            py = ty - int'($signed(cfg_shadow.offset_row));
            if (px < -512 || px > 511) px = rand_pos();
            if (py < -512 || py > 511) py = rand_pos();
        end
        roll = $urandom_range(0, 19);
        if (roll < 3) ch = int'(SPACE_CHAR);
        else if (roll == 3) ch = 0;
        else ch = $urandom_range(0, 255);
        push_cmd(FUNC_PUT, px, py, ch, $urandom_range(0, 31));
    endfunction

    // One frame: optional clear, a few puts, then a full scan (sometimes cut short).
    function automatic int push_frame(input int sync_cap);
        int w, h, cells, n_put, n_sync, cnt, roll;
        cnt   = 0;
        w     = (int'(cfg_shadow.screen_width) > COLS) ? COLS : int'(cfg_shadow.screen_width);
        h     = (int'(cfg_shadow.screen_height) > ROWS) ? ROWS : int'(cfg_shadow.screen_height);
        cells = w * h;
        roll  = $urandom_range(0, 99);
        if (roll < 20) begin
            push_cmd(FUNC_BEGIN, rand_pos(), rand_pos(), $urandom_range(0, 255),
                     $urandom_range(0, 31));
            cnt++;
        end else if (roll < 26) begin
            push_cmd(FUNC_INVAL, rand_pos(), rand_pos(), $urandom_range(0, 255),
                     $urandom_range(0, 31));
            cnt++;
        end
        n_put = $urandom_range(0, 8);
        repeat (n_put) begin
            push_random_put(w, h);
            cnt++;
        end
        n_sync = cells + 1;
        if ($urandom_range(0, 6) == 0) n_sync = $urandom_range(0, cells + 2);
        if (n_sync > sync_cap) n_sync = sync_cap;
        repeat (n_sync) begin
            if ($urandom_range(0, 19) == 0) begin
                push_random_put(w, h);
                cnt++;
            end
            push_cmd(FUNC_SYNC, rand_pos(), rand_pos(), $urandom_range(0, 255),
                     $urandom_range(0, 31));
            cnt++;
        end
        return cnt;
    endfunction

    // Register settings per phase; the first ones hit the extremes.
    function automatic t_cfg phase_cfg(input int p);
        t_cfg c;
        c = '0;
        c.clip_width  = COL_W'(COLS);
        c.clip_height = ROW_W'(ROWS);
        case (p)
            0: begin
                c.screen_width  = 8'd8;
                c.screen_height = 6'd4;
            end
            1: begin
                c.offset_col    = POS_W'(-512);
                c.offset_row    = POS_W'(-512);
                c.screen_width  = 8'd5;
                c.screen_height = 6'd3;
            end
            2: begin
                c.offset_col    = POS_W'(511);
                c.offset_row    = POS_W'(511);
                c.screen_width  = 8'd6;
                c.screen_height = 6'd3;
            end
            3: begin
                c.offset_col    = POS_W'(-3);
                c.offset_row    = POS_W'(2);
                c.clip_left     = 8'd2;
                c.clip_top      = 6'd1;
                c.clip_width    = 8'd3;
                c.clip_height   = 6'd2;
                c.screen_width  = 8'd7;
                c.screen_height = 6'd4;
            end
            4: begin
                // Oversized screen and clip rectangle in the far corner.
                c.offset_col    = POS_W'(150);
                c.offset_row    = POS_W'(40);
                c.clip_left     = 8'd159;
                c.clip_top      = 6'd49;
                c.screen_width  = 8'd255;
                c.screen_height = 6'd63;
            end
            5: begin
                c.clip_width  = '0;
                c.clip_height = '0;
            end
            6: begin
                c.screen_width  = 8'd1;
                c.screen_height = ROW_W'(ROWS);
            end
            7: begin
                c.screen_width  = COL_W'(COLS);
                c.screen_height = 6'd1;
            end
            8: begin
                c.offset_col    = POS_W'(int'($urandom_range(0, 12)) - 6);
                c.offset_row    = POS_W'(int'($urandom_range(0, 12)) - 6);
                c.clip_left     = 8'd100;
                c.clip_top      = 6'd40;
                c.clip_width    = 8'd60;
                c.clip_height   = 6'd10;
                c.screen_width  = COL_W'(COLS);
                c.screen_height = ROW_W'(ROWS);
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    c.offset_col = POS_W'(int'($urandom_range(0, 12)) - 6);
                    c.offset_row = POS_W'(int'($urandom_range(0, 12)) - 6);
                end else begin
                    c.offset_col = POS_W'($urandom);
                    c.offset_row = POS_W'($urandom);
                end
                c.clip_left = COL_W'($urandom_range(0, 15));
                c.clip_top  = ROW_W'($urandom_range(0, 7));
                if ($urandom_range(0, 1) == 1) c.clip_width = COL_W'($urandom_range(0, COLS));
                if ($urandom_range(0, 1) == 1) c.clip_height = ROW_W'($urandom_range(0, ROWS));
                c.screen_width  = COL_W'($urandom_range(1, 12));
                c.screen_height = ROW_W'($urandom_range(1, 6));
            end
        endcase
        return c;
    endfunction

    function automatic int phase_quota(input int p);
        case (p)
            0, 3:   return 100;
            1:      return 40;
            2, 4, 7: return 60;
            5:      return 25;
            6:      return 70;
            8:      return 50;
            default: return 50;
        endcase
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic apb_write(input logic [2:0] reg_idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_cfg(input t_cfg c);
        apb_write(REG_OFFSET_COL,    CFG_DW'(c.offset_col));
        apb_write(REG_OFFSET_ROW,    CFG_DW'(c.offset_row));
        apb_write(REG_CLIP_LEFT,     CFG_DW'(c.clip_left));
        apb_write(REG_CLIP_TOP,      CFG_DW'(c.clip_top));
        apb_write(REG_CLIP_WIDTH,    CFG_DW'(c.clip_width));
        apb_write(REG_CLIP_HEIGHT,   CFG_DW'(c.clip_height));
        apb_write(REG_SCREEN_WIDTH,  CFG_DW'(c.screen_width));
        apb_write(REG_SCREEN_HEIGHT, CFG_DW'(c.screen_height));
        cfg_shadow = c;
    endtask

    // Waits until every command is taken and every record is in, then lets a
    // store sweep run out, since clears and unchanged cells produce no record.
    task automatic settle_block();
        while (screen_cmds.size() != 0 || cmd_chan.valid) @(posedge i_clk);
        while (due_records.size() != 0) @(posedge i_clk);
        repeat (SWEEP_CYCLES + 100) @(posedge i_clk);
    endtask

    // Command sender: bursts of random length with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_chan.valid <= 1'b0;
        end else if (!(cmd_chan.valid && !item_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                cmd_chan.valid <= 1'b0;
            end else if (screen_cmds.size() != 0) begin
                taken_cmd = screen_cmds.pop_front();
                cmd_chan.valid       <= 1'b1;
                cmd_chan.func        <= taken_cmd.func;
                cmd_chan.pos_col     <= taken_cmd.pos_col;
                cmd_chan.pos_row     <= taken_cmd.pos_row;
                cmd_chan.glyph_char  <= taken_cmd.glyph_char;
                cmd_chan.glyph_style <= taken_cmd.glyph_style;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                cmd_chan.valid <= 1'b0;
            end
        end
    end

    // Record receiver: alternates between always ready, random and mostly stalled.
    always @(negedge i_clk) begin
        if (rdy_left <= 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(5, 80);
        end
        rdy_left--;
        case (rdy_mode)
            0:       rec_chan.ready <= 1'b1;
            1:       rec_chan.ready <= $urandom_range(0, 1);
            default: rec_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Input side: every command transfer updates the screen model.
    always @(posedge i_clk) begin
        item_taken <= cmd_chan.valid && cmd_chan.ready;
        if (cmd_chan.valid && cmd_chan.ready) begin
            taken_cmd.func        = t_func'(cmd_chan.func);
            taken_cmd.pos_col     = cmd_chan.pos_col;
            taken_cmd.pos_row     = cmd_chan.pos_row;
            taken_cmd.glyph_char  = cmd_chan.glyph_char;
            taken_cmd.glyph_style = cmd_chan.glyph_style;
            apply_screen_cmd(taken_cmd);
        end
    end

    // Output side: each record transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (rec_chan.valid && rec_chan.ready) begin
            got_rec.record_kind = rec_chan.record_kind;
            got_rec.cell_row    = rec_chan.cell_row;
            got_rec.cell_col    = rec_chan.cell_col;
            got_rec.out_char    = rec_chan.out_char;
            got_rec.out_style   = rec_chan.out_style;
            got_rec.restyle     = t_restyle'(rec_chan.restyle);
            got_rec.move_cursor = rec_chan.move_cursor;
            if (due_records.size() == 0) begin
                bad_records++;
                if (bad_records <= MISMATCH_SHOWN)
                    $display("unexpected record: kind=%0d row=%0d col=%0d char=%h",
                             got_rec.record_kind, got_rec.cell_row, got_rec.cell_col,
                             got_rec.out_char);
            end else begin
                want_rec = due_records.pop_front();
                if (got_rec.record_kind !== want_rec.record_kind
                        || got_rec.cell_row !== want_rec.cell_row
                        || got_rec.cell_col !== want_rec.cell_col
                        || got_rec.out_char !== want_rec.out_char
                        || got_rec.out_style !== want_rec.out_style
                        || got_rec.restyle !== want_rec.restyle
                        || got_rec.move_cursor !== want_rec.move_cursor) begin
                    bad_records++;
                    if (bad_records <= MISMATCH_SHOWN) begin
                        $display("mismatch want: kind=%0d row=%0d col=%0d char=%h %s",
                                 want_rec.record_kind, want_rec.cell_row,
                                 want_rec.cell_col, want_rec.out_char, "");
                        $display("   want style=%0d restyle=%0d move=%0d",
                                 want_rec.out_style, want_rec.restyle,
                                 want_rec.move_cursor);
                        $display("   got kind=%0d row=%0d col=%0d char=%h",
                                 got_rec.record_kind, got_rec.cell_row,
                                 got_rec.cell_col, got_rec.out_char);
                        $display("   got style=%0d restyle=%0d move=%0d",
                                 got_rec.out_style, got_rec.restyle,
                                 got_rec.move_cursor);
                    end
                end
            end
        end
    end

    // Stimulus: reset, a directed frame on a 3 by 2 screen, then random phases.
    initial begin
        t_cfg c;
        int   p;
        int   quota;
        int   n;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_chan.valid       = 1'b0;
        cmd_chan.func        = FUNC_BEGIN;
        cmd_chan.pos_col     = '0;
        cmd_chan.pos_row     = '0;
        cmd_chan.glyph_char  = '0;
        cmd_chan.glyph_style = '0;
        rec_chan.ready       = 1'b0;
        item_taken           = 1'b0;
        bad_records          = 0;
        burst_left           = 1;
        gap_left             = 0;
        rdy_mode             = 0;
        rdy_left             = 0;
        foreach (shown_img[i]) shown_img[i] = {{STYLE_W{1'b0}}, SPACE_CHAR};
        foreach (drawn_img[i]) drawn_img[i] = '0;
        cur_col    = 0;
        cur_row    = 0;
        scan_pos   = 0;
        cur_style  = '0;
        cfg_shadow = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        c = '0;
        c.clip_width    = COL_W'(COLS);
        c.clip_height   = ROW_W'(ROWS);
        c.screen_width  = 8'd3;
        c.screen_height = 6'd2;
        load_cfg(c);

        // First scan reports every cell, since the shown store starts as spaces.
        repeat (7) push_cmd(FUNC_SYNC, 0, 0, 0, 0);
        // Style changes, a stored space, an out-of-range style, a glyph that
        // equals the shown cell, a skipped cell and puts far outside the store.
        push_cmd(FUNC_PUT, 0, 0, 'h41, 3);
        push_cmd(FUNC_PUT, 1, 0, int'(SPACE_CHAR), 29);
        push_cmd(FUNC_PUT, 2, 0, 'hFF, 31);
        push_cmd(FUNC_PUT, 1, 1, 0, 30);
        push_cmd(FUNC_PUT, 2, 1, 'h7E, 0);
        push_cmd(FUNC_PUT, -512, 511, 'h55, 1);
        push_cmd(FUNC_PUT, 511, -512, 'hAA, 2);
        repeat (7) push_cmd(FUNC_SYNC, 0, 0, 0, 0);
        push_cmd(FUNC_BEGIN, 0, 0, 0, 0);
        push_cmd(FUNC_SYNC, 0, 0, 0, 0);
        push_cmd(FUNC_INVAL, 0, 0, 0, 0);
        push_cmd(FUNC_SYNC, 0, 0, 0, 0);

        for (p = 0; p < 14; p++) begin
            settle_block();
            load_cfg(phase_cfg(p));
            quota = phase_quota(p);
            n = 0;
            while (n < quota) n += push_frame(60);
        end
        settle_block();

        if (bad_records == 0 && due_records.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tsdr_pkg.sv
sv/tsdr_if.sv
sv/tsdr_ctrl.sv
sv/tsdr_dp.sv
sv/text_screen_delta_refresh.sv
dv/tb_top.sv
